// ===== src/id3v2_tag_frame_parser_macros.svh =====
// assertion macros shared by the id3 parser modules
// expects clk_i and rst_ni in the scope of every use
`ifndef ID3V2_TAG_FRAME_PARSER_MACROS_SVH
`define ID3V2_TAG_FRAME_PARSER_MACROS_SVH

// same-cycle implication, checked out of reset
`define ID3_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ID3_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== src/id3_pkg.sv =====
// types, codes and the frame id table for the id3v2 tag and frame parser
// no dependencies
package id3_pkg;

  typedef enum logic [1:0] {
    PH_TAG     = 2'd0,
    PH_FRAME   = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_STOP    = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    REC_TAG   = 2'd0,
    REC_START = 2'd1,
    REC_DATA  = 2'd2,
    REC_STOP  = 2'd3
  } rec_kind_e;

  localparam int unsigned NumIds  = 6;
  localparam logic [3:0]  HdrLast = 4'd9;   // index of the tenth header byte

  // ids indexed by frame_kind; the list runs from kind 5 (TRCK) down to kind 0 (TPE1)
  localparam logic [NumIds-1:0][31:0] KnownIds = '{
    32'h5452434B,  // TRCK
    32'h54434F4E,  // TCON
    32'h54594552,  // TYER
    32'h54495432,  // TIT2
    32'h54414C42,  // TALB
    32'h54504531   // TPE1
  };

  typedef struct packed {
    logic       found;
    logic [2:0] kind;
  } id_hit_t;

  typedef struct packed {
    rec_kind_e   rec_kind;
    logic [7:0]  tag_version;
    logic [7:0]  tag_revision;
    logic [7:0]  tag_flags;
    logic [27:0] tag_size;
    logic [2:0]  frame_kind;
    logic [27:0] frame_size;
    logic [15:0] frame_flags;
    logic [7:0]  data_byte;
    logic        last_of_frame;
  } rec_t;

  function automatic id_hit_t id_lookup(logic [31:0] id);
    id_hit_t hit;
    hit = '0;
    for (int i = NumIds - 1; i >= 0; i--) begin
      if (id == KnownIds[i]) begin
        hit.found = 1'b1;
        hit.kind  = 3'(i);
      end
    end
    return hit;
  endfunction

endpackage

// ===== src/id3_core.sv =====
// parse state and record building, one byte per accepted transaction
// depends on id3_pkg and the assertion macro header
`include "id3v2_tag_frame_parser_macros.svh"

module id3_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_fire_i,
  input  logic [7:0]    in_byte_i,
  input  logic          start_of_tag_i,
  output logic          rec_valid_o,
  output id3_pkg::rec_t rec_o
);
  import id3_pkg::*;

  phase_e      phase_q, phase_d, phase_eff;
  logic [3:0]  count_q, count_d, count_eff;
  logic [27:0] size_q, size_d;
  logic [31:0] id_q, id_d;
  logic [7:0]  flag_q, flag_d;
  logic [7:0]  ver_q, ver_d;
  logic [7:0]  rev_q, rev_d;
  logic [27:0] left_q, left_d;
  logic [2:0]  kind_q, kind_d;
  logic [27:0] size_shifted;
  logic        hdr_done;
  logic        left_last;
  id_hit_t     hit;

  // start of tag restarts the parse at byte 0 of the tag header
  assign phase_eff    = start_of_tag_i ? PH_TAG : phase_q;
  assign count_eff    = start_of_tag_i ? 4'd0 : count_q;
  assign size_shifted = {size_q[20:0], in_byte_i[6:0]};
  assign hdr_done     = (count_eff == HdrLast);
  assign left_last    = (left_q <= 28'd1);
  assign hit          = id_lookup(id_q);

  // next state
  always_comb begin
    phase_d = phase_eff;
    case (phase_eff)
      PH_TAG: begin
        if (hdr_done) phase_d = PH_FRAME;
      end
      PH_FRAME: begin
        if (hdr_done) begin
          if (!hit.found)        phase_d = PH_STOP;
          else if (size_q != '0) phase_d = PH_PAYLOAD;
          else                   phase_d = PH_FRAME;
        end
      end
      PH_PAYLOAD: begin
        if (left_last) phase_d = PH_FRAME;
      end
      PH_STOP: phase_d = PH_STOP;
      default: phase_d = PH_TAG;
    endcase
  end

  // datapath registers and the record
  always_comb begin
    count_d     = count_eff;
    size_d      = size_q;
    id_d        = id_q;
    flag_d      = flag_q;
    ver_d       = ver_q;
    rev_d       = rev_q;
    left_d      = left_q;
    kind_d      = kind_q;
    rec_valid_o = 1'b0;
    rec_o       = '0;
    case (phase_eff)
      PH_TAG: begin
        case (count_eff)
          4'd3:    ver_d  = in_byte_i;
          4'd4:    rev_d  = in_byte_i;
          4'd5:    flag_d = in_byte_i;
          default: begin
            if (count_eff >= 4'd6) size_d = size_shifted;
          end
        endcase
        if (hdr_done) begin
          rec_valid_o        = 1'b1;
          rec_o.rec_kind     = REC_TAG;
          rec_o.tag_version  = ver_q;
          rec_o.tag_revision = rev_q;
          rec_o.tag_flags    = flag_q;
          rec_o.tag_size     = size_shifted;
          count_d            = '0;
          size_d             = '0;
          id_d               = '0;
          flag_d             = '0;
        end else begin
          count_d = count_eff + 4'd1;
        end
      end
      PH_FRAME: begin
        if (count_eff < 4'd4)      id_d   = {id_q[23:0], in_byte_i};
        else if (count_eff < 4'd8) size_d = size_shifted;
        else if (count_eff == 4'd8) flag_d = in_byte_i;
        if (hdr_done) begin
          rec_valid_o = 1'b1;
          count_d     = '0;
          if (!hit.found) begin
            rec_o.rec_kind = REC_STOP;
          end else begin
            rec_o.rec_kind    = REC_START;
            rec_o.frame_kind  = hit.kind;
            rec_o.frame_size  = size_q;
            rec_o.frame_flags = {flag_q, in_byte_i};
            kind_d            = hit.kind;
            left_d            = size_q;
            size_d            = '0;
            id_d              = '0;
            flag_d            = '0;
          end
        end else begin
          count_d = count_eff + 4'd1;
        end
      end
      PH_PAYLOAD: begin
        rec_valid_o         = 1'b1;
        rec_o.rec_kind      = REC_DATA;
        rec_o.data_byte     = in_byte_i;
        rec_o.last_of_frame = left_last;
        if (left_last) begin
          left_d  = '0;
          count_d = '0;
        end else begin
          left_d = left_q - 28'd1;
        end
      end
      PH_STOP: ;
      default: ;
    endcase
    if (!in_fire_i) rec_valid_o = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TAG;
      count_q <= '0;
      size_q  <= '0;
      id_q    <= '0;
      flag_q  <= '0;
      ver_q   <= '0;
      rev_q   <= '0;
      left_q  <= '0;
      kind_q  <= '0;
    end else if (in_fire_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      size_q  <= size_d;
      id_q    <= id_d;
      flag_q  <= flag_d;
      ver_q   <= ver_d;
      rev_q   <= rev_d;
      left_q  <= left_d;
      kind_q  <= kind_d;
    end
  end

  `ID3_ASSERT_IMP(a_count_range, 1'b1, count_q <= HdrLast, "header byte count out of range")
  `ID3_ASSERT_IMP(a_stop_silent, (phase_q == PH_STOP) && !start_of_tag_i, !rec_valid_o,
                  "record produced after stop")
  `ID3_ASSERT_IMP(a_payload_left, phase_q == PH_PAYLOAD, left_q != '0,
                  "payload phase with nothing left")

endmodule

// ===== src/id3_skid.sv =====
// output register plus one skid entry for parser records
// depends on id3_pkg and the assertion macro header
`include "id3v2_tag_frame_parser_macros.svh"

module id3_skid (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  id3_pkg::rec_t rec_i,
  output logic          ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output id3_pkg::rec_t out_o
);
  import id3_pkg::*;

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  rec_t out_q, out_d;
  rec_t skid_q, skid_d;

  assign ready_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    // drain first so a freed output register takes the older record
    if (out_valid_q && out_ready_i) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
    if (push_i) begin
      if (!out_valid_d) begin
        out_d       = rec_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = rec_i;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  `ID3_ASSERT_IMP(a_skid_behind_out, skid_valid_q, out_valid_q,
                  "skid entry held with empty output register")
  `ID3_ASSERT_IMP(a_no_push_full, push_i, !skid_valid_q, "record pushed into full buffer")
  `ID3_ASSERT_NEXT(a_skid_moves_up, skid_valid_q && out_ready_i, out_q == $past(skid_q),
                   "skid entry not moved to output")

endmodule

// ===== src/id3v2_tag_frame_parser.sv =====
// id3v2 tag and frame header parser: one file byte in, at most one record out
// latency: a record is on m_axis the cycle after its byte is accepted when the output is free
// throughput: one byte per cycle; s_axis_tready drops only while the skid entry is full
// bytes are accepted while a record waits at the output, unless the skid entry is full too
// reset (async, active low): parse returns to the tag header, output buffer empties
// depends on id3_pkg, id3_core and id3_skid
module id3v2_tag_frame_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // in_byte
  input  logic          s_axis_tuser,   // start_of_tag
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // tag_version, tag_revision, tag_flags, tag_size, frame_kind, frame_size,
  // frame_flags, data_byte, zero fill
  output logic [111:0]  m_axis_tdata,
  output logic [1:0]    m_axis_tuser,   // rec_kind
  output logic          m_axis_tlast    // last_of_frame
);
  import id3_pkg::*;

  logic in_fire;
  logic rec_valid;
  rec_t rec;
  rec_t out_rec;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  id3_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_fire_i      (in_fire),
    .in_byte_i      (s_axis_tdata),
    .start_of_tag_i (s_axis_tuser),
    .rec_valid_o    (rec_valid),
    .rec_o          (rec)
  );

  id3_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (rec_valid),
    .rec_i       (rec),
    .ready_o     (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (out_rec)
  );

  assign m_axis_tdata = {5'd0,
                         out_rec.data_byte,
                         out_rec.frame_flags,
                         out_rec.frame_size,
                         out_rec.frame_kind,
                         out_rec.tag_size,
                         out_rec.tag_flags,
                         out_rec.tag_revision,
                         out_rec.tag_version};
  assign m_axis_tuser = out_rec.rec_kind;
  assign m_axis_tlast = out_rec.last_of_frame;

endmodule

// ===== tb/sv/id3v2_tag_frame_parser_test.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the id3v2 tag and frame parser: byte stream in, records out
// depends on id3_pkg and id3v2_tag_frame_parser; predicts every record and checks it in order
module id3v2_tag_frame_parser_test;
  import id3_pkg::*;

  localparam int          ByteTarget = 550;
  localparam int          DrainLimit = 20000;
  localparam int          SettleCyc  = 8;
  localparam logic [3:0]  VerPos     = 4'd3;
  localparam logic [3:0]  RevPos     = 4'd4;
  localparam logic [3:0]  FlgPos     = 4'd5;
  localparam logic [3:0]  IdEnd      = 4'd4;   // frame header: bytes below this are the id
  localparam logic [3:0]  SizeEnd    = 4'd8;   // frame header: size bytes end, first flag byte
  localparam logic [23:0] TagMarker  = 24'h494433;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_COMB, RX_CHOKE} rx_mode_e;

  logic          clk_i;
  logic          rst_ni;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [7:0]    s_axis_tdata;
  logic          s_axis_tuser;
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  logic [111:0]  m_axis_tdata;
  logic [1:0]    m_axis_tuser;
  logic          m_axis_tlast;

  // parser state mirrored by the predictor
  phase_e        prs_phase;
  logic [3:0]    prs_idx;
  logic [27:0]   prs_size;
  logic [31:0]   prs_id;
  logic [7:0]    prs_flag;
  logic [7:0]    prs_ver;
  logic [7:0]    prs_rev;
  logic [27:0]   prs_left;
  logic [2:0]    prs_kind;

  rec_t          pending_records[$];
  int            errors = 0;
  int            bytes_sent = 0;
  int            rec_seen[4] = '{0, 0, 0, 0};
  int            burst_left = 0;
  bit            tx_gaps = 1'b0;
  rx_mode_e      rx_mode = RX_OPEN;
  int            rx_tick = 0;
  int            choke_left = 0;

  id3v2_tag_frame_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d records outstanding", pending_records.size());
    $display("id3v2_tag_frame_parser: mismatch");
    $finish;
  end

  function automatic void clear_parse();
    prs_phase = PH_TAG;
    prs_idx   = '0;
    prs_size  = '0;
    prs_id    = '0;
    prs_flag  = '0;
    prs_ver   = '0;
    prs_rev   = '0;
    prs_left  = '0;
    prs_kind  = '0;
  endfunction

  // expected record, if any, for one accepted byte
  function automatic void parse_byte(logic [7:0] b, logic sot);
    rec_t r;
    bit   emit;
    bit   found;
    r     = '0;
    emit  = 1'b0;
    found = 1'b0;
    if (sot) clear_parse();
    case (prs_phase)
      PH_TAG: begin
        if (prs_idx == VerPos) prs_ver = b;
        else if (prs_idx == RevPos) prs_rev = b;
        else if (prs_idx == FlgPos) prs_flag = b;
        else if (prs_idx > FlgPos) prs_size = {prs_size[20:0], b[6:0]};
        if (prs_idx != HdrLast) begin
          prs_idx++;
        end else begin
          r.rec_kind     = REC_TAG;
          r.tag_version  = prs_ver;
          r.tag_revision = prs_rev;
          r.tag_flags    = prs_flag;
          r.tag_size     = prs_size;
          emit      = 1'b1;
          prs_phase = PH_FRAME;
          prs_idx   = '0;
          prs_size  = '0;
          prs_id    = '0;
          prs_flag  = '0;
        end
      end
      PH_FRAME: begin
        if (prs_idx < IdEnd) prs_id = {prs_id[23:0], b};
        else if (prs_idx < SizeEnd) prs_size = {prs_size[20:0], b[6:0]};
        else if (prs_idx == SizeEnd) prs_flag = b;
        if (prs_idx != HdrLast) begin
          prs_idx++;
        end else begin
          for (int i = 0; i < NumIds; i++) begin
            if (!found && prs_id == KnownIds[i]) begin
              found    = 1'b1;
              prs_kind = 3'(i);
            end
          end
          prs_idx = '0;
          emit    = 1'b1;
          if (!found) begin
            r.rec_kind = REC_STOP;
            prs_phase  = PH_STOP;
          end else begin
            r.rec_kind    = REC_START;
            r.frame_kind  = prs_kind;
            r.frame_size  = prs_size;
            r.frame_flags = {prs_flag, b};
            prs_left  = prs_size;
            prs_phase = (prs_size == '0) ? PH_FRAME : PH_PAYLOAD;
            prs_size  = '0;
            prs_id    = '0;
            prs_flag  = '0;
          end
        end
      end
      PH_PAYLOAD: begin
        r.rec_kind      = REC_DATA;
        r.data_byte     = b;
        r.last_of_frame = (prs_left <= 28'd1);
        emit = 1'b1;
        if (prs_left <= 28'd1) begin
          prs_left  = '0;
          prs_phase = PH_FRAME;
          prs_idx   = '0;
        end else begin
          prs_left--;
        end
      end
      default: ;
    endcase
    if (emit) pending_records.push_back(r);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // check the output transaction first, then predict from the input transaction
  always @(posedge clk_i) begin
    rec_t got;
    rec_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.rec_kind      = rec_kind_e'(m_axis_tuser);
      got.tag_version   = m_axis_tdata[7:0];
      got.tag_revision  = m_axis_tdata[15:8];
      got.tag_flags     = m_axis_tdata[23:16];
      got.tag_size      = m_axis_tdata[51:24];
      got.frame_kind    = m_axis_tdata[54:52];
      got.frame_size    = m_axis_tdata[82:55];
      got.frame_flags   = m_axis_tdata[98:83];
      got.data_byte     = m_axis_tdata[106:99];
      got.last_of_frame = m_axis_tlast;
      rec_seen[m_axis_tuser]++;
      if (pending_records.size() == 0) begin
        $display("%0t ns: record kind %0d with none expected", $time, m_axis_tuser);
        errors++;
      end else begin
        want = pending_records.pop_front();
        check_field("rec_kind", want.rec_kind, got.rec_kind);
        check_field("tag_version", want.tag_version, got.tag_version);
        check_field("tag_revision", want.tag_revision, got.tag_revision);
        check_field("tag_flags", want.tag_flags, got.tag_flags);
        check_field("tag_size", want.tag_size, got.tag_size);
        check_field("frame_kind", want.frame_kind, got.frame_kind);
        check_field("frame_size", want.frame_size, got.frame_size);
        check_field("frame_flags", want.frame_flags, got.frame_flags);
        check_field("data_byte", want.data_byte, got.data_byte);
        check_field("last_of_frame", want.last_of_frame, got.last_of_frame);
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata, s_axis_tuser);
  end

  // receiver stall pattern
  always @(negedge clk_i) begin
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      RX_OPEN:  m_axis_tready <= 1'b1;
      RX_COIN:  m_axis_tready <= ($urandom_range(0, 2) != 0);
      RX_COMB:  m_axis_tready <= (rx_tick % 5 < 3);
      RX_CHOKE: begin
        if (choke_left == 0) begin
          choke_left    <= $urandom_range(1, 12);
          m_axis_tready <= ~m_axis_tready;
        end else begin
          choke_left <= choke_left - 1;
        end
      end
      default:  m_axis_tready <= 1'b1;
    endcase
  end

  task automatic send_byte(input logic [7:0] b, input logic sot);
    @(negedge clk_i);
    if (tx_gaps && burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tdata  <= b;
    s_axis_tuser  <= sot;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  // ten header bytes, first byte in the top bits
  task automatic send_header(input logic [79:0] hdr, input logic sot);
    for (int i = 9; i >= 0; i--) send_byte(hdr[i*8 +: 8], (i == 9) ? sot : 1'b0);
  endtask

  task automatic send_payload(input int n);
    repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // syncsafe size bytes; junk sets the ignored top bit of each byte at random
  function automatic logic [31:0] syncsafe(logic [27:0] s, bit junk);
    logic [31:0] v;
    v = {1'b0, s[27:21], 1'b0, s[20:14], 1'b0, s[13:7], 1'b0, s[6:0]};
    if (junk) v |= {$urandom_range(0, 1) == 1, 7'd0, $urandom_range(0, 1) == 1, 7'd0,
                    $urandom_range(0, 1) == 1, 7'd0, $urandom_range(0, 1) == 1, 7'd0};
    return v;
  endfunction

  task automatic wait_idle();
    int n;
    n = 0;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_records.size() != 0 && n < DrainLimit) begin
      @(posedge clk_i);
      n++;
    end
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic test_tag_limits();
    rx_mode = RX_OPEN;
    tx_gaps = 1'b0;
    send_header({TagMarker, 8'h00, 8'h00, 8'h00, 32'h0000_0000}, 1'b1);
    send_header({KnownIds[0], 32'h0000_0000, 16'h0000}, 1'b0);   // empty frame
    send_header({24'hFFFFFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF}, 1'b1);
    wait_idle();
  endtask

  task automatic test_frames_and_stop();
    rx_mode = RX_COIN;
    tx_gaps = 1'b1;
    send_header({TagMarker, 8'h04, 8'h00, 8'h40, syncsafe(28'd300, 1'b1)}, 1'b1);
    send_header({KnownIds[5], syncsafe(28'd2, 1'b1) | 32'h8080_8080, 16'hFFFF}, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_header({KnownIds[1], syncsafe(28'd1, 1'b0), 16'h8001}, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_header({32'hFFFF_FFFF, 32'h0000_0001, 16'h0000}, 1'b0);  // unknown id stops
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    wait_idle();
  endtask

  task automatic test_restart();
    rx_mode = RX_CHOKE;
    tx_gaps = 1'b1;
    send_header({TagMarker, 8'h03, 8'h01, 8'h00, 32'h0000_0101}, 1'b1);
    send_header({KnownIds[2], 32'hFFFF_FFFF, 16'h1234}, 1'b0);  // largest size
    send_payload(3);
    send_header({TagMarker, 8'h04, 8'h02, 8'h80, 32'h7F7F_7F7F}, 1'b1);  // restart mid payload
    for (int i = 0; i < 5; i++) send_byte(8'h54, 1'b0);
    send_header({TagMarker, 8'h02, 8'h00, 8'h00, 32'h0000_0010}, 1'b1);  // restart mid header
    wait_idle();
  endtask

  task automatic send_random_file();
    logic [23:0] marker;
    logic [27:0] fsize;
    int          nframes;
    int          ending;
    marker  = ($urandom_range(0, 4) == 0) ? 24'($urandom) : TagMarker;
    rx_mode = rx_mode_e'($urandom_range(0, 3));
    tx_gaps = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 9) == 0) begin
      send_byte(8'($urandom_range(0, 255)), 1'b1);
      repeat ($urandom_range(0, 8)) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end
    send_header({marker, 8'($urandom), 8'($urandom), 8'($urandom), 32'($urandom)}, 1'b1);
    nframes = $urandom_range(0, 4);
    repeat (nframes) begin
      case ($urandom_range(0, 9))
        0:       fsize = '0;
        1, 2:    fsize = 28'($urandom_range(7, 24));
        default: fsize = 28'($urandom_range(1, 6));
      endcase
      send_header({KnownIds[$urandom_range(0, NumIds - 1)],
                   syncsafe(fsize, $urandom_range(0, 1) == 1), 16'($urandom)}, 1'b0);
      send_payload(fsize);
    end
    ending = $urandom_range(0, 9);
    case (ending)
      0, 1, 2, 3, 4: begin
        // stop on an unknown id, either random or one bit off a known one
        if (ending == 4)
          send_header({KnownIds[$urandom_range(0, NumIds - 1)] ^ (32'd1 << $urandom_range(0, 31)),
                       32'($urandom), 16'($urandom)}, 1'b0);
        else
          send_header({32'($urandom), 32'($urandom), 16'($urandom)}, 1'b0);
        repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      5: begin
        // long frame cut short by the next file
        fsize = ($urandom_range(0, 1) == 1) ? 28'($urandom) : 28'($urandom_range(25, 4000));
        send_header({KnownIds[$urandom_range(0, NumIds - 1)], syncsafe(fsize, 1'b0),
                     16'($urandom)}, 1'b0);
        send_payload($urandom_range(0, 6));
      end
      6: repeat ($urandom_range(1, 9)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      default: ;
    endcase
  endtask

  task automatic test_random_files();
    while (bytes_sent < ByteTarget) send_random_file();
    wait_idle();
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    clear_parse();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_tag_limits();
    test_frames_and_stop();
    test_restart();
    test_random_files();

    if (pending_records.size() != 0) begin
      $display("%0d expected records never arrived", pending_records.size());
      errors += pending_records.size();
    end
    $display("sent %0d bytes; checked %0d tag, %0d frame start, %0d payload, %0d stop records",
             bytes_sent, rec_seen[REC_TAG], rec_seen[REC_START], rec_seen[REC_DATA],
             rec_seen[REC_STOP]);
    $display("restarts in every parse phase, unknown ids, empty frames, %0d field errors",
             errors);
    if (errors == 0) begin
      $display("id3v2_tag_frame_parser: match");
    end else begin
      $display("id3v2_tag_frame_parser: mismatch");
    end
    $finish;
  end

endmodule
